>>> hdl/bdph_pkg.sv
// Shared types, codes and constants for the push-button debouncer.
package bdph_pkg;

  // Debounce window geometry.
  localparam int WIN_LEN    = 5;
  localparam int HIGH_VOTES = 4;
  localparam int CNT_W      = $clog2(WIN_LEN + 1);

  // Configuration port geometry.
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  // Register byte addresses.
  localparam logic [CFG_AW-1:0] ADDR_ACCEL_MAX  = 4'd0;
  localparam logic [CFG_AW-1:0] ADDR_ACCEL_MIN  = 4'd4;
  localparam logic [CFG_AW-1:0] ADDR_ACCEL_STEP = 4'd8;

  // Register reset values.
  localparam logic [7:0] ACCEL_MAX_RST  = 8'd100;
  localparam logic [7:0] ACCEL_MIN_RST  = 8'd20;
  localparam logic [7:0] ACCEL_STEP_RST = 8'd10;

  // Timer constants.
  localparam logic [7:0] TIMER_CAP     = 8'd254;
  localparam logic [7:0] TIMER_ONCE    = 8'd255;
  localparam logic [7:0] SHORT_LIMIT   = 8'd10;
  localparam logic [7:0] REPEAT_RELOAD = 8'd10;
  localparam logic [8:0] INTERVAL_MAX  = 9'd511;

  // Item modes.
  localparam logic [2:0] MODE_TICK  = 3'd0;
  localparam logic [2:0] MODE_CHECK = 3'd1;
  localparam logic [2:0] MODE_PRESS = 3'd2;
  localparam logic [2:0] MODE_HOLD  = 3'd3;
  localparam logic [2:0] MODE_ACCEL = 3'd4;

  // Level and event codes.
  localparam logic [1:0] LEVEL_NONE = 2'd0;
  localparam logic [1:0] LEVEL_LOW  = 2'd1;
  localparam logic [1:0] LEVEL_HIGH = 2'd2;

  // Configuration values handed to the datapath.
  typedef struct packed {
    logic [7:0] accel_max;
    logic [7:0] accel_min;
    logic [7:0] accel_step;
  } cfg_t;

endpackage

>>> hdl/bdph_in_if.sv
// Input channel: one sample tick or query per transaction.
interface bdph_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic       raw_sample;
  logic [1:0] query_event;
  logic       clear_flag;
  logic [7:0] hold_threshold;
  logic       once_flag;

  modport source (
    output valid, mode, raw_sample, query_event, clear_flag, hold_threshold, once_flag,
    input  ready
  );
  modport sink (
    input  valid, mode, raw_sample, query_event, clear_flag, hold_threshold, once_flag,
    output ready
  );
endinterface

>>> hdl/bdph_out_if.sv
// Result channel: one answer per transaction.
interface bdph_out_if;
  logic       valid;
  logic       ready;
  logic       hit;
  logic [1:0] level;
  logic [7:0] hold_ticks;

  modport source (
    output valid, hit, level, hold_ticks,
    input  ready
  );
  modport sink (
    input  valid, hit, level, hold_ticks,
    output ready
  );
endinterface

>>> hdl/bdph_regs.sv
// APB-style configuration register file for the auto-repeat settings.
module bdph_regs
  import bdph_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready,
  output cfg_t              cfg
);

  cfg_t cfg_r;
  logic wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg        = cfg_r;

  // Register writes; addresses beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.accel_max  <= ACCEL_MAX_RST;
      cfg_r.accel_min  <= ACCEL_MIN_RST;
      cfg_r.accel_step <= ACCEL_STEP_RST;
    end else if (wr_en) begin
      case (cfg_paddr)
        ADDR_ACCEL_MAX:  cfg_r.accel_max  <= cfg_pwdata[7:0];
        ADDR_ACCEL_MIN:  cfg_r.accel_min  <= cfg_pwdata[7:0];
        ADDR_ACCEL_STEP: cfg_r.accel_step <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    case (cfg_paddr)
      ADDR_ACCEL_MAX:  cfg_prdata = {{(CFG_DW-8){1'b0}}, cfg_r.accel_max};
      ADDR_ACCEL_MIN:  cfg_prdata = {{(CFG_DW-8){1'b0}}, cfg_r.accel_min};
      ADDR_ACCEL_STEP: cfg_prdata = {{(CFG_DW-8){1'b0}}, cfg_r.accel_step};
      default:         cfg_prdata = '0;
    endcase
  end

endmodule

>>> hdl/button_debounce_press_hold.sv
// Push-button debouncer with event latch, hold timer and auto-repeat.
// The result of a transaction is registered and presented in the cycle after acceptance.
// Throughput: one transaction per cycle; the state update is a single registered pass
// and the result register frees whenever the sink takes its content.
// Reset (synchronous, active low): released level, window all ones, no pending event,
// hold timer 0, repeat interval and registers at their reset values.
module button_debounce_press_hold
  import bdph_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  bdph_in_if.sink           in_ch,
  bdph_out_if.source        out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  cfg_t cfg;

  bdph_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // Debouncer state.
  logic [WIN_LEN-1:0] window_r,   window_nxt;
  logic [CNT_W-1:0]   ones_r,     ones_nxt;
  logic [1:0]         level_r,    level_nxt;
  logic [1:0]         pend_r,     pend_nxt;
  logic [7:0]         timer_r,    timer_nxt;
  logic [8:0]         interval_r, interval_nxt;
  logic               hit_nxt;

  // Result register.
  logic       out_valid_r;
  logic       out_hit_r;
  logic [1:0] out_level_r;
  logic [7:0] out_ticks_r;

  logic       accept;
  logic [1:0] new_level;
  logic [8:0] floor_sum;
  logic [8:0] grown;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign floor_sum = {1'b0, cfg.accel_min} + {1'b0, cfg.accel_step};
  assign grown     = {1'b0, cfg.accel_max} + {1'b0, REPEAT_RELOAD} + 9'd1;

  // Sliding-window vote for a sample tick.
  always_comb begin
    window_nxt = {window_r[WIN_LEN-2:0], in_ch.raw_sample};
    ones_nxt   = ones_r - CNT_W'(window_r[WIN_LEN-1]) + CNT_W'(in_ch.raw_sample);
    new_level  = (32'(ones_nxt) >= HIGH_VOTES) ? LEVEL_HIGH : LEVEL_LOW;
  end

  // Per-transaction state update.
  always_comb begin
    level_nxt    = level_r;
    pend_nxt     = pend_r;
    timer_nxt    = timer_r;
    interval_nxt = interval_r;
    hit_nxt      = 1'b0;
    case (in_ch.mode)
      MODE_TICK: begin
        if (new_level != level_r) begin
          level_nxt = new_level;
          pend_nxt  = new_level;
          if (new_level == LEVEL_LOW) timer_nxt = '0;
        end else if (new_level == LEVEL_LOW && timer_r < TIMER_CAP) begin
          timer_nxt = timer_r + 8'd1;
        end
      end
      MODE_CHECK: begin
        if (pend_r == in_ch.query_event) begin
          if (in_ch.clear_flag) pend_nxt = LEVEL_NONE;
          hit_nxt = 1'b1;
        end
      end
      MODE_PRESS: begin
        if (pend_r == LEVEL_HIGH && timer_r < SHORT_LIMIT) begin
          pend_nxt = LEVEL_NONE;
          hit_nxt  = 1'b1;
        end
      end
      MODE_HOLD: begin
        if (pend_r == LEVEL_LOW && timer_r > in_ch.hold_threshold && timer_r != TIMER_ONCE) begin
          timer_nxt = in_ch.once_flag ? TIMER_ONCE : REPEAT_RELOAD;
          hit_nxt   = 1'b1;
        end
      end
      MODE_ACCEL: begin
        if (pend_r == LEVEL_HIGH) begin
          interval_nxt = {1'b0, cfg.accel_max};
        end else if ({1'b0, timer_r} > interval_r) begin
          if (interval_r == {1'b0, cfg.accel_max}) begin
            interval_nxt = (grown > INTERVAL_MAX) ? INTERVAL_MAX : grown;
          end else if (interval_r > floor_sum) begin
            interval_nxt = interval_r - {1'b0, cfg.accel_step};
          end
          timer_nxt = REPEAT_RELOAD;
          hit_nxt   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r   <= '1;
      ones_r     <= CNT_W'(WIN_LEN);
      level_r    <= LEVEL_HIGH;
      pend_r     <= LEVEL_NONE;
      timer_r    <= '0;
      interval_r <= {1'b0, ACCEL_MAX_RST};
    end else if (accept) begin
      if (in_ch.mode == MODE_TICK) begin
        window_r <= window_nxt;
        ones_r   <= ones_nxt;
      end
      level_r    <= level_nxt;
      pend_r     <= pend_nxt;
      timer_r    <= timer_nxt;
      interval_r <= interval_nxt;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload, taken after the update.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_hit_r   <= hit_nxt;
      out_level_r <= level_nxt;
      out_ticks_r <= timer_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.hit        = out_hit_r;
  assign out_ch.level      = out_level_r;
  assign out_ch.hold_ticks = out_ticks_r;

endmodule

>>> dv/tb.sv
// Self-checking testbench for the push-button debouncer: directed and random ticks and queries.
module tb
  import bdph_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Codes beyond the package set: spare modes and the check query that never matches.
  localparam logic [2:0] MODE_SPARE_LO = 3'd5;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;
  localparam logic [1:0] QUERY_BAD     = 2'd3;
  localparam int         NUM_PHASES    = 6;
  localparam int         PHASE_ITEMS   = 115;

  typedef struct packed {
    logic [2:0] mode;
    logic       raw_sample;
    logic [1:0] query_event;
    logic       clear_flag;
    logic [7:0] hold_threshold;
    logic       once_flag;
  } item_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] level;
    logic [7:0] hold_ticks;
  } answer_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  bdph_in_if  in_ch ();
  bdph_out_if out_ch ();

  button_debounce_press_hold dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // Stimulus and scoreboard storage.
  item_t   button_items_q[$];
  answer_t expected_answers_q[$];
  int      errors       = 0;
  int      stim_count   = 0;
  int      items_sent   = 0;
  int      answers_seen = 0;
  int      query_hits   = 0;
  bit      idle_on      = 1'b1;
  int      send_gap     = 0;
  int      sink_stall   = 0;

  // Predictor state and register mirror, starting at their reset values.
  logic [WIN_LEN-1:0] win_q         = '1;
  int                 votes_q       = WIN_LEN;
  logic [1:0]         level_q       = LEVEL_HIGH;
  logic [1:0]         pending_q     = LEVEL_NONE;
  logic [7:0]         timer_q       = '0;
  logic [8:0]         interval_q    = {1'b0, ACCEL_MAX_RST};
  logic [7:0]         accel_max_cfg = ACCEL_MAX_RST;
  logic [7:0]         accel_min_cfg = ACCEL_MIN_RST;
  logic [7:0]         accel_step_cfg = ACCEL_STEP_RST;

  // Advance the predicted debouncer by one item and return its answer.
  function automatic answer_t debounce_predict(item_t it);
    answer_t    res;
    logic [1:0] lvl;
    int         floor_sum;
    int         grown;
    res.hit = 1'b0;
    floor_sum = int'(accel_min_cfg) + int'(accel_step_cfg);
    case (it.mode)
      MODE_TICK: begin
        votes_q = votes_q - int'(win_q[WIN_LEN-1]) + int'(it.raw_sample);
        win_q = {win_q[WIN_LEN-2:0], it.raw_sample};
        lvl = (votes_q >= HIGH_VOTES) ? LEVEL_HIGH : LEVEL_LOW;
        if (lvl != level_q) begin
          level_q = lvl;
          pending_q = lvl;
          if (lvl == LEVEL_LOW) timer_q = '0;
        end else if (lvl == LEVEL_LOW && timer_q < TIMER_CAP) begin
          timer_q = timer_q + 8'd1;
        end
      end
      MODE_CHECK: begin
        if (pending_q == it.query_event) begin
          if (it.clear_flag) pending_q = LEVEL_NONE;
          res.hit = 1'b1;
        end
      end
      MODE_PRESS: begin
        if (pending_q == LEVEL_HIGH && timer_q < SHORT_LIMIT) begin
          pending_q = LEVEL_NONE;
          res.hit = 1'b1;
        end
      end
      MODE_HOLD: begin
        if (pending_q == LEVEL_LOW && timer_q > it.hold_threshold && timer_q != TIMER_ONCE) begin
          timer_q = it.once_flag ? TIMER_ONCE : REPEAT_RELOAD;
          res.hit = 1'b1;
        end
      end
      MODE_ACCEL: begin
        // A pending release reloads the interval; a long enough hold fires, widens a full interval, else steps it down.
        if (pending_q == LEVEL_HIGH) begin
          interval_q = {1'b0, accel_max_cfg};
        end else if ({1'b0, timer_q} > interval_q) begin
          if (interval_q == {1'b0, accel_max_cfg}) begin
            grown = int'(accel_max_cfg) + 1 + int'(REPEAT_RELOAD);
            interval_q = (grown > int'(INTERVAL_MAX)) ? INTERVAL_MAX : 9'(grown);
          end else if (int'(interval_q) > floor_sum) begin
            interval_q = interval_q - {1'b0, accel_step_cfg};
          end
          timer_q = REPEAT_RELOAD;
          res.hit = 1'b1;
        end
      end
      default: ;
    endcase
    res.level = level_q;
    res.hold_ticks = timer_q;
    return res;
  endfunction

  function automatic item_t make_item(logic [2:0] mode, logic raw, logic [1:0] query,
                                      logic clear, logic [7:0] thresh, logic once);
    item_t it;
    it.mode = mode;
    it.raw_sample = raw;
    it.query_event = query;
    it.clear_flag = clear;
    it.hold_threshold = thresh;
    it.once_flag = once;
    return it;
  endfunction

  // Fully random item, any mode and any field value.
  function automatic item_t rand_noise();
    return make_item(3'($urandom_range(0, 7)), 1'($urandom), 2'($urandom), 1'($urandom),
                     8'($urandom), 1'($urandom));
  endfunction

  function automatic item_t tick_item(logic raw);
    item_t it;
    it = rand_noise();
    it.mode = MODE_TICK;
    it.raw_sample = raw;
    return it;
  endfunction

  // Query with random content, thresholds mostly small so that holds can report.
  function automatic item_t rand_query();
    item_t it;
    it = rand_noise();
    case ($urandom_range(0, 9))
      0, 1, 2: it.mode = MODE_CHECK;
      3, 4:    it.mode = MODE_PRESS;
      5, 6:    it.mode = MODE_HOLD;
      7, 8:    it.mode = MODE_ACCEL;
      default: it.mode = 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
    endcase
    if ($urandom_range(0, 3) != 0) it.hold_threshold = 8'($urandom_range(0, 24));
    return it;
  endfunction

  task automatic push_item(item_t it);
    button_items_q.push_back(it);
    stim_count++;
  endtask

  // One button press: bouncy low stretch and release, with queries sprinkled in.
  task automatic press_gesture(input int low_len, input int bounce_pct);
    int i;
    int rel_len;
    rel_len = $urandom_range(4, 12);
    for (i = 0; i < low_len; i++) begin
      push_item(tick_item(($urandom_range(0, 99) < bounce_pct) ? 1'b1 : 1'b0));
      if ($urandom_range(0, 3) == 0) push_item(rand_query());
    end
    for (i = 0; i < rel_len; i++) begin
      push_item(tick_item(($urandom_range(0, 99) < bounce_pct) ? 1'b0 : 1'b1));
      if ($urandom_range(0, 2) == 0) push_item(rand_query());
    end
  endtask

  // Wait until every queued transaction has been accepted and answered.
  task automatic wait_drained();
    while (button_items_q.size() != 0 || in_ch.valid || expected_answers_q.size() != 0)
      @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // APB access: setup cycle, then access cycle until pready; reads are checked.
  task automatic cfg_access(input logic wr, input logic [CFG_AW-1:0] addr,
                            input logic [7:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= addr;
    cfg_pwdata <= wr ? CFG_DW'(val) : '0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (!wr && cfg_prdata !== CFG_DW'(val)) begin
      errors++;
      $display("%0t: register 0x%0h read expected 0x%0h actual 0x%0h", $time, addr,
               CFG_DW'(val), cfg_prdata);
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (wr) begin
      case (addr)
        ADDR_ACCEL_MAX:  accel_max_cfg = val;
        ADDR_ACCEL_MIN:  accel_min_cfg = val;
        ADDR_ACCEL_STEP: accel_step_cfg = val;
        default: ;
      endcase
    end
  endtask

  task automatic program_accel(input logic [7:0] vmax, input logic [7:0] vmin,
                               input logic [7:0] vstep);
    cfg_access(1'b1, ADDR_ACCEL_MAX, vmax);
    cfg_access(1'b1, ADDR_ACCEL_MIN, vmin);
    cfg_access(1'b1, ADDR_ACCEL_STEP, vstep);
    cfg_access(1'b0, ADDR_ACCEL_MAX, vmax);
    cfg_access(1'b0, ADDR_ACCEL_MIN, vmin);
    cfg_access(1'b0, ADDR_ACCEL_STEP, vstep);
  endtask

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Input driver: presents queued items, predicts each accepted transaction.
  always @(posedge clk) begin : drive_proc
    item_t   nxt;
    answer_t ans;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        ans = debounce_predict(make_item(in_ch.mode, in_ch.raw_sample, in_ch.query_event,
                                         in_ch.clear_flag, in_ch.hold_threshold,
                                         in_ch.once_flag));
        expected_answers_q.push_back(ans);
        items_sent++;
        if (ans.hit) query_hits++;
      end
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (button_items_q.size() != 0) begin
          nxt = button_items_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.mode <= nxt.mode;
          in_ch.raw_sample <= nxt.raw_sample;
          in_ch.query_event <= nxt.query_event;
          in_ch.clear_flag <= nxt.clear_flag;
          in_ch.hold_threshold <= nxt.hold_threshold;
          in_ch.once_flag <= nxt.once_flag;
          send_gap = idle_on ? $urandom_range(0, 11) : 0;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: random backpressure and field-by-field comparison.
  always @(posedge clk) begin : check_proc
    answer_t exp_ans;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      sink_stall = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        answers_seen++;
        if (expected_answers_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected transaction hit %0d level %0d hold_ticks %0d", $time,
                   out_ch.hit, out_ch.level, out_ch.hold_ticks);
        end else begin
          exp_ans = expected_answers_q.pop_front();
          if (out_ch.hit !== exp_ans.hit) begin
            errors++;
            $display("%0t: hit expected %0d actual %0d", $time, exp_ans.hit, out_ch.hit);
          end
          if (out_ch.level !== exp_ans.level) begin
            errors++;
            $display("%0t: level expected %0d actual %0d", $time, exp_ans.level,
                     out_ch.level);
          end
          if (out_ch.hold_ticks !== exp_ans.hold_ticks) begin
            errors++;
            $display("%0t: hold_ticks expected %0d actual %0d", $time, exp_ans.hold_ticks,
                     out_ch.hold_ticks);
          end
        end
        sink_stall = idle_on ? $urandom_range(0, 11) : 0;
      end
      if (sink_stall > 0) begin
        sink_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Stimulus sequence: reset, directed items, then register phases of random gestures.
  initial begin
    int          ph;
    int          phase_start;
    int          pick;
    logic [7:0]  vmax;
    logic [7:0]  vmin;
    logic [7:0]  vstep;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_TICK;
    in_ch.raw_sample = 1'b0;
    in_ch.query_event = LEVEL_NONE;
    in_ch.clear_flag = 1'b0;
    in_ch.hold_threshold = '0;
    in_ch.once_flag = 1'b0;
    out_ch.ready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Registers come up at their reset values.
    cfg_access(1'b0, ADDR_ACCEL_MAX, ACCEL_MAX_RST);
    cfg_access(1'b0, ADDR_ACCEL_MIN, ACCEL_MIN_RST);
    cfg_access(1'b0, ADDR_ACCEL_STEP, ACCEL_STEP_RST);

    // Directed: empty latch, impossible query, fall, once-hold marker, spare modes, rise.
    push_item(make_item(MODE_CHECK, 1'b0, LEVEL_NONE, 1'b1, 8'd0, 1'b0));
    push_item(make_item(MODE_CHECK, 1'b1, QUERY_BAD, 1'b1, 8'd255, 1'b1));
    push_item(make_item(MODE_PRESS, 1'b0, LEVEL_NONE, 1'b0, 8'd0, 1'b0));
    push_item(tick_item(1'b0));
    push_item(tick_item(1'b0));
    push_item(make_item(MODE_CHECK, 1'b0, LEVEL_LOW, 1'b0, 8'd0, 1'b0));
    push_item(make_item(MODE_HOLD, 1'b0, LEVEL_NONE, 1'b0, 8'd255, 1'b0));
    push_item(tick_item(1'b0));
    push_item(tick_item(1'b0));
    push_item(make_item(MODE_HOLD, 1'b0, LEVEL_NONE, 1'b0, 8'd0, 1'b1));
    push_item(make_item(MODE_HOLD, 1'b0, LEVEL_NONE, 1'b0, 8'd0, 1'b0));
    push_item(tick_item(1'b0));
    push_item(make_item(MODE_ACCEL, 1'b0, LEVEL_NONE, 1'b0, 8'd0, 1'b0));
    push_item(make_item(MODE_SPARE_LO, 1'b1, LEVEL_HIGH, 1'b1, 8'd255, 1'b1));
    push_item(make_item(MODE_SPARE_LO + 3'd1, 1'b1, LEVEL_LOW, 1'b1, 8'd0, 1'b0));
    push_item(make_item(MODE_SPARE_HI, 1'b0, QUERY_BAD, 1'b0, 8'd128, 1'b1));
    push_item(make_item(MODE_HOLD, 1'b0, LEVEL_NONE, 1'b0, 8'd9, 1'b0));
    repeat (4) push_item(tick_item(1'b1));
    push_item(make_item(MODE_PRESS, 1'b0, LEVEL_NONE, 1'b0, 8'd0, 1'b0));
    push_item(make_item(MODE_ACCEL, 1'b0, LEVEL_NONE, 1'b0, 8'd0, 1'b0));
    push_item(make_item(MODE_CHECK, 1'b0, LEVEL_HIGH, 1'b1, 8'd0, 1'b0));
    push_item(make_item(MODE_CHECK, 1'b0, LEVEL_NONE, 1'b0, 8'd0, 1'b0));
    wait_drained();

    // Random phases, each under its own register setting; phase boundaries stall the sender.
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       begin vmax = 8'd100; vmin = 8'd20;  vstep = 8'd10; end
        1:       begin vmax = 8'd0;   vmin = 8'd0;   vstep = 8'd0;  end
        2:       begin vmax = 8'd255; vmin = 8'd255; vstep = 8'd255; end
        3:       begin vmax = 8'd12;  vmin = 8'd3;   vstep = 8'd2;  end
        4:       begin vmax = 8'd20;  vmin = 8'd5;   vstep = 8'd7;  end
        default: begin vmax = 8'd6;   vmin = 8'd0;   vstep = 8'd1;  end
      endcase
      wait_drained();
      program_accel(vmax, vmin, vstep);
      idle_on = (ph != 1 && ph != 4);
      phase_start = stim_count;
      // A press long enough to saturate the hold timer.
      if (ph == 0 || ph == 2) press_gesture(300, 0);
      while (stim_count - phase_start < PHASE_ITEMS) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) press_gesture($urandom_range(2, 40), $urandom_range(0, 20));
        else if (pick < 9) repeat (8) push_item(rand_noise());
        else press_gesture($urandom_range(40, 90), $urandom_range(0, 5));
      end
    end

    wait_drained();
    repeat (4) @(posedge clk);
    $display("Run covered %0d transactions over %0d register settings, %0d answers checked.",
             items_sent, NUM_PHASES, answers_seen);
    $display("Queries that reported a hit: %0d.", query_hits);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #(20_000_000);
    $display("Mismatches found");
    $finish;
  end

endmodule

>>> files.f
hdl/bdph_pkg.sv
hdl/bdph_in_if.sv
hdl/bdph_out_if.sv
hdl/bdph_regs.sv
hdl/button_debounce_press_hold.sv
dv/tb.sv
